>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define RTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RTI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/rti_pkg.sv
`timescale 1ns / 1ps

package rti_pkg;

    localparam int TABLE_POINTS = 16;
    localparam int AXIS_COUNT   = 6;
    localparam int STORE_DEPTH  = AXIS_COUNT * TABLE_POINTS;

    localparam int IDX_W  = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int AX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int CNT_W  = $clog2(TABLE_POINTS + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int DATA_W      = 32;
    localparam int Q_FRAC_BITS = 16;
    localparam int FRAC_W      = Q_FRAC_BITS + 1;
    localparam int OPND_W      = DATA_W + 1;
    localparam int PROD_W      = 2 * OPND_W - Q_FRAC_BITS;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << Q_FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [AX_W-1:0]   ax_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SET   = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_INTERP   = 3'd0,
        ST_CLAMP_LO = 3'd1,
        ST_CLAMP_HI = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BAD_DOF  = 3'd4
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] freq;
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] phase;
    } point_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        point_t data;
    } mem_wr_t;

    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [Q_FRAC_BITS-1:0] quotient;
    } div_rsp_t;

    function automatic addr_t point_addr(ax_t axis, idx_t idx);
        return addr_t'(axis) * addr_t'(TABLE_POINTS) + addr_t'(idx);
    endfunction

endpackage

>>> rtl/rti_if.sv
`timescale 1ns / 1ps

interface rti_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         dof;
    logic [3:0]         point_index;
    logic [4:0]         point_count;
    logic signed [31:0] point_frequency;
    logic signed [31:0] point_gain;
    logic signed [31:0] point_phase;
    logic signed [31:0] query_frequency;
    logic signed [31:0] wave_amplitude;

    modport source (
        output valid, kind, dof, point_index, point_count, point_frequency,
               point_gain, point_phase, query_frequency, wave_amplitude,
        input  ready
    );

    modport sink (
        input  valid, kind, dof, point_index, point_count, point_frequency,
               point_gain, point_phase, query_frequency, wave_amplitude,
        output ready
    );
endinterface

interface rti_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] response_amplitude;
    logic signed [31:0] response_phase;
    logic [2:0]         status;

    modport source (
        output valid, response_amplitude, response_phase, status,
        input  ready
    );

    modport sink (
        input  valid, response_amplitude, response_phase, status,
        output ready
    );
endinterface

>>> rtl/rti_point_mem.sv
`timescale 1ns / 1ps

module rti_point_mem (
    input  logic               clk,
    input  rti_pkg::mem_wr_t   wr,
    input  rti_pkg::addr_t     raddr,
    output rti_pkg::point_t    rdata
);

    rti_pkg::point_t store [rti_pkg::STORE_DEPTH];
    rti_pkg::point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store[wr.addr] <= wr.data;
        end
    end

    // Registered read: data for the address shown now appears next cycle.
    always_ff @(posedge clk)
    begin
        rdata_reg <= store[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rti_mul.sv
`timescale 1ns / 1ps

module rti_mul (
    input  logic                                clk,
    input  rti_pkg::mul_req_t                   op,
    output logic signed [rti_pkg::PROD_W-1:0]   prod
);

    logic signed [rti_pkg::OPND_W-1:0]   opnd_a;
    logic signed [rti_pkg::OPND_W-1:0]   opnd_b;
    logic signed [2*rti_pkg::OPND_W-1:0] full;
    logic signed [rti_pkg::PROD_W-1:0]   prod_reg;

    assign opnd_a = op.a;
    assign opnd_b = op.b;
    assign full   = opnd_a * opnd_b;

    // Drop the fraction bits: an arithmetic shift floors towards minus infinity.
    always_ff @(posedge clk)
    begin
        prod_reg <= full[2*rti_pkg::OPND_W-1:rti_pkg::Q_FRAC_BITS];
    end

    assign prod = prod_reg;

endmodule

>>> rtl/rti_divider.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rti_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rti_pkg::div_req_t req,
    output rti_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(rti_pkg::Q_FRAC_BITS + 1);
    typedef logic [CNT_W-1:0] step_t;

    logic                            busy_reg;
    logic                            done_reg;
    step_t                           cnt_reg;
    logic [rti_pkg::DATA_W-1:0]      rem_reg;
    logic [rti_pkg::DATA_W-1:0]      divisor_reg;
    logic [rti_pkg::Q_FRAC_BITS-1:0] quo_reg;
    logic [rti_pkg::DATA_W:0]        rem_shift;
    logic                            fits;

    // Dividend is below the divisor, so the remainder always stays below it.
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= step_t'(rti_pkg::Q_FRAC_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - step_t'(1);
            done_reg <= (cnt_reg == step_t'(1));
            busy_reg <= (cnt_reg != step_t'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rti_pkg::DATA_W'(rem_shift - {1'b0, divisor_reg})
                            : rem_shift[rti_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[rti_pkg::Q_FRAC_BITS-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `RTI_ASSERT_IMPL(a_no_restart, clk, rst_n, req.start, !busy_reg, "divider restarted while busy")
    `RTI_ASSERT_NEXT(a_last_step_done, clk, rst_n, busy_reg && (cnt_reg == step_t'(1)), done_reg && !busy_reg, "divider missed its final step")

endmodule

>>> rtl/rao_table_interpolator_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Payload
// req       in   kind, dof, point_index, point_count, point_frequency, point_gain,
//                point_phase, query_frequency, wave_amplitude
// rsp       out  response_amplitude, response_phase, status
//
// Write and set transactions are taken in S_IDLE and complete there; kind 3 is
// dropped. A query with a bad dof or an empty table goes straight to S_OUT; a
// clamped one reads the end points and scales the wave; an interpolated one
// scans the points serially through the single read port of the point store
// and, unless the fraction is pinned, waits on the 16-step fraction divider.
// rst_n clears the sequencer, the output valid and the point counts; the point
// store itself is never cleared. A stalled rsp holds the result in the output
// register while the next transaction is taken; a finished query waits until
// the register is free.

module rao_table_interpolator_core (
    input  logic      clk,
    input  logic      rst_n,
    rti_in_if.sink    req,
    rti_out_if.source rsp
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_RD0        = 11'b000_0000_0010,
        S_RDN        = 11'b000_0000_0100,
        S_SCAN       = 11'b000_0000_1000,
        S_FRAC       = 11'b000_0001_0000,
        S_DIV        = 11'b000_0010_0000,
        S_LERP_GAIN  = 11'b000_0100_0000,
        S_LERP_PHASE = 11'b000_1000_0000,
        S_SCALE      = 11'b001_0000_0000,
        S_SAT        = 11'b010_0000_0000,
        S_OUT        = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Per-axis point counts: a handful of flops, reset to empty.
    rti_pkg::cnt_t axis_count_reg [rti_pkg::AXIS_COUNT];

    // Query context
    rti_pkg::ax_t                      ax_reg;
    rti_pkg::cnt_t                     n_reg;
    logic signed [31:0]                q_reg;
    logic signed [31:0]                wave_reg;
    rti_pkg::idx_t                     j_reg;
    rti_pkg::point_t                   lo_reg;
    logic signed [rti_pkg::OPND_W-1:0] delta_reg;
    logic signed [rti_pkg::OPND_W-1:0] span_reg;
    logic signed [rti_pkg::OPND_W-1:0] dgain_reg;
    logic signed [rti_pkg::OPND_W-1:0] dphase_reg;
    logic [rti_pkg::FRAC_W-1:0]        frac_reg;
    logic [31:0]                       gain_i_reg;

    // Finished result, then the output register
    logic [31:0]      res_amp_reg;
    logic [31:0]      res_ph_reg;
    rti_pkg::status_t res_st_reg;
    logic             out_valid_reg;
    logic [31:0]      out_amp_reg;
    logic [31:0]      out_ph_reg;
    rti_pkg::status_t out_st_reg;

    logic                              req_fire;
    logic                              is_write;
    logic                              is_set;
    logic                              is_query;
    logic                              dof_ok;
    logic                              pidx_ok;
    rti_pkg::cnt_t                     req_count;
    rti_pkg::cnt_t                     new_count;
    rti_pkg::idx_t                     last_idx;
    rti_pkg::ax_t                      rd_axis;
    rti_pkg::idx_t                     rd_idx;
    rti_pkg::point_t                   rd_point;
    rti_pkg::mem_wr_t                  mem_wr;
    logic                              scan_stop;
    logic                              frac_edge;
    logic                              out_free;
    logic [31:0]                       amp_sat;
    rti_pkg::mul_req_t                 mul_req;
    logic signed [rti_pkg::PROD_W-1:0] mul_p;
    rti_pkg::div_req_t                 div_req;
    rti_pkg::div_rsp_t                 div_rsp;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign is_write  = (req.kind == rti_pkg::KIND_WRITE);
    assign is_set    = (req.kind == rti_pkg::KIND_SET);
    assign is_query  = (req.kind == rti_pkg::KIND_QUERY);
    assign dof_ok    = (int'(req.dof) < rti_pkg::AXIS_COUNT);
    assign pidx_ok   = (int'(req.point_index) < rti_pkg::TABLE_POINTS);
    assign req_count = dof_ok ? axis_count_reg[rti_pkg::ax_t'(req.dof)] : '0;
    assign new_count = (int'(req.point_count) > rti_pkg::TABLE_POINTS)
                     ? rti_pkg::cnt_t'(rti_pkg::TABLE_POINTS)
                     : rti_pkg::cnt_t'(req.point_count);
    assign last_idx  = rti_pkg::idx_t'(n_reg - rti_pkg::cnt_t'(1));
    assign out_free  = !out_valid_reg || rsp.ready;

    // Point writes go straight to the store on acceptance.
    assign mem_wr.en   = req_fire && is_write && dof_ok && pidx_ok;
    assign mem_wr.addr = rti_pkg::point_addr(rti_pkg::ax_t'(req.dof),
                                             rti_pkg::idx_t'(req.point_index));
    assign mem_wr.data = '{freq:  req.point_frequency,
                           gain:  req.point_gain,
                           phase: req.point_phase};

    // Read address for the point needed next cycle.
    always_comb
    begin
        rd_axis = ax_reg;
        rd_idx  = '0;
        case (state_reg)
            S_IDLE:
            begin
                rd_axis = rti_pkg::ax_t'(req.dof);
            end
            S_RD0:
            begin
                rd_idx = last_idx;
            end
            S_RDN:
            begin
                rd_idx = rti_pkg::idx_t'(1);
            end
            S_SCAN:
            begin
                rd_idx = j_reg + rti_pkg::idx_t'(1);
            end
            default:
            begin
                rd_idx = '0;
            end
        endcase
    end

    rti_point_mem u_point_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (rti_pkg::point_addr(rd_axis, rd_idx)),
        .rdata (rd_point)
    );

    // Stop on the first upper point above the query, or at the last point.
    assign scan_stop = ($signed(q_reg) < $signed(rd_point.freq)) || (j_reg == last_idx);

    // Query at or below the lower point, or at or beyond the upper one: no divide.
    assign frac_edge = (delta_reg <= 0) || (delta_reg >= span_reg);

    assign div_req.start    = (state_reg == S_FRAC) && !frac_edge;
    assign div_req.dividend = delta_reg[31:0];
    assign div_req.divisor  = span_reg[31:0];

    rti_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The shared multiplier: gain scaling by default, interpolation terms when lerping.
    always_comb
    begin
        mul_req.a = {wave_reg[31], wave_reg};
        mul_req.b = {gain_i_reg[31], gain_i_reg};
        case (state_reg)
            S_RD0, S_RDN:
            begin
                mul_req.b = {rd_point.gain[31], rd_point.gain};
            end
            S_LERP_GAIN:
            begin
                mul_req.a = dgain_reg;
                mul_req.b = {{(rti_pkg::OPND_W - rti_pkg::FRAC_W){1'b0}}, frac_reg};
            end
            S_LERP_PHASE:
            begin
                mul_req.a = dphase_reg;
                mul_req.b = {{(rti_pkg::OPND_W - rti_pkg::FRAC_W){1'b0}}, frac_reg};
            end
            default:
            begin
                mul_req.a = {wave_reg[31], wave_reg};
            end
        endcase
    end

    rti_mul u_mul (
        .clk  (clk),
        .op   (mul_req),
        .prod (mul_p)
    );

    // Saturate the scaled amplitude to the signed 32-bit range.
    always_comb
    begin
        if (!mul_p[rti_pkg::PROD_W-1] && (|mul_p[rti_pkg::PROD_W-2:31]))
        begin
            amp_sat = rti_pkg::SAT_MAX;
        end
        else if (mul_p[rti_pkg::PROD_W-1] && !(&mul_p[rti_pkg::PROD_W-2:31]))
        begin
            amp_sat = rti_pkg::SAT_MIN;
        end
        else
        begin
            amp_sat = mul_p[31:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && is_query)
                begin
                    if (!dof_ok || (req_count == '0))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                if ($signed(q_reg) <= $signed(rd_point.freq))
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                if ($signed(q_reg) >= $signed(rd_point.freq))
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                state_next = frac_edge ? S_LERP_GAIN : S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_LERP_GAIN;
                end
            end
            S_LERP_GAIN:
            begin
                state_next = S_LERP_PHASE;
            end
            S_LERP_PHASE:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, point counts, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < rti_pkg::AXIS_COUNT; k++)
            begin
                axis_count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire && is_set && dof_ok)
            begin
                axis_count_reg[rti_pkg::ax_t'(req.dof)] <= new_count;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && is_query)
                begin
                    ax_reg      <= rti_pkg::ax_t'(req.dof);
                    n_reg       <= req_count;
                    q_reg       <= req.query_frequency;
                    wave_reg    <= req.wave_amplitude;
                    // Preload the answer for a bad dof or an empty table.
                    res_amp_reg <= dof_ok ? req.wave_amplitude : '0;
                    res_ph_reg  <= '0;
                    res_st_reg  <= dof_ok ? rti_pkg::ST_EMPTY : rti_pkg::ST_BAD_DOF;
                end
            end
            S_RD0:
            begin
                lo_reg     <= rd_point;
                res_ph_reg <= rd_point.phase;
                res_st_reg <= rti_pkg::ST_CLAMP_LO;
            end
            S_RDN:
            begin
                res_ph_reg <= rd_point.phase;
                res_st_reg <= rti_pkg::ST_CLAMP_HI;
                j_reg      <= rti_pkg::idx_t'(1);
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    delta_reg  <= {q_reg[31], q_reg} - {lo_reg.freq[31], lo_reg.freq};
                    span_reg   <= {rd_point.freq[31], rd_point.freq}
                                - {lo_reg.freq[31], lo_reg.freq};
                    dgain_reg  <= {rd_point.gain[31], rd_point.gain}
                                - {lo_reg.gain[31], lo_reg.gain};
                    dphase_reg <= {rd_point.phase[31], rd_point.phase}
                                - {lo_reg.phase[31], lo_reg.phase};
                end
                else
                begin
                    lo_reg <= rd_point;
                    j_reg  <= j_reg + rti_pkg::idx_t'(1);
                end
            end
            S_FRAC:
            begin
                if (delta_reg <= 0)
                begin
                    frac_reg <= '0;
                end
                else if (delta_reg >= span_reg)
                begin
                    frac_reg <= rti_pkg::FRAC_ONE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_reg <= {1'b0, div_rsp.quotient};
                end
            end
            S_LERP_PHASE:
            begin
                gain_i_reg <= lo_reg.gain + mul_p[31:0];
            end
            S_SCALE:
            begin
                res_ph_reg <= lo_reg.phase + mul_p[31:0];
                res_st_reg <= rti_pkg::ST_INTERP;
            end
            S_SAT:
            begin
                res_amp_reg <= amp_sat;
            end
            default:
            begin
            end
        endcase

        if ((state_reg == S_OUT) && out_free)
        begin
            out_amp_reg <= res_amp_reg;
            out_ph_reg  <= res_ph_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.response_amplitude = out_amp_reg;
    assign rsp.response_phase     = out_ph_reg;
    assign rsp.status             = out_st_reg;

    `RTI_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, div_rsp.done, state_reg == S_DIV, "divider result outside the divide wait")
    `RTI_ASSERT_IMPL(a_scan_in_table, clk, rst_n, state_reg == S_SCAN, (j_reg != '0) && (j_reg <= last_idx), "scan index outside the table")
    `RTI_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_OUT) && out_free, out_valid_reg && (state_reg == S_IDLE), "finished query not presented")

endmodule

>>> bench/rao_table_interpolator_core_test.sv
`timescale 1ns / 1ps

module rao_table_interpolator_core_test;

    import rti_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_GOAL      = 1850;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 64;
    localparam int REPORT_LIMIT   = 10;

    // Kind 3 is not decoded by the block; it must be dropped without a response.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_UNIT = 32'sh0001_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
    localparam longint             FRAC_UNIT = 64'sd65536;

    typedef struct {
        logic [1:0]         kind;
        logic [2:0]         dof;
        logic [3:0]         point_index;
        logic [4:0]         point_count;
        logic signed [31:0] point_frequency;
        logic signed [31:0] point_gain;
        logic signed [31:0] point_phase;
        logic signed [31:0] query_frequency;
        logic signed [31:0] wave_amplitude;
    } transaction_t;

    typedef struct {
        logic signed [31:0] amplitude;
        logic signed [31:0] phase;
        status_t            status;
    } response_t;

    typedef struct {
        transaction_t txn;
        bit           fixed;
        response_t    answer;
    } plan_row_t;

    logic clk;
    logic rst_n;

    rti_in_if  req_ch ();
    rti_out_if rsp_ch ();

    rao_table_interpolator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Mirror of the point store and the per-axis point counts.
    logic signed [31:0] pt_freq  [STORE_DEPTH];
    logic signed [31:0] pt_gain  [STORE_DEPTH];
    logic signed [31:0] pt_phase [STORE_DEPTH];
    int unsigned        axis_points [AXIS_COUNT];

    // Responses still owed by the block, oldest first.
    response_t awaited [$];
    response_t no_answer;

    int  accepted_items  = 0;
    int  counted_items   = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  holdoffs_done   = 0;
    int  quiet_cycles    = 0;
    int  status_seen [5] = '{default: 0};
    bit  no_idle         = 1'b0;

    // Directed opening. Rows with a typed response are the ones that can be
    // read straight off the spec: empty tables, bad axis, clamping with
    // saturation. The rest go through the predictor like the random part.
    // The point store is fully written beforehand, so any count is safe.
    plan_row_t plan [26] = '{
        // empty tables straight after reset: wave passes through, phase zero
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, 0, Q_MAX}, 1'b1, '{Q_MAX, 0, ST_EMPTY}},
        '{'{KIND_QUERY, 3'd5, 4'd0, 5'd0, 0, 0, 0, Q_MIN, Q_MIN}, 1'b1, '{Q_MIN, 0, ST_EMPTY}},
        // invalid axes answer with zeros
        '{'{KIND_QUERY, 3'd6, 4'd0, 5'd0, 0, 0, 0, 0, Q_UNIT}, 1'b1, '{0, 0, ST_BAD_DOF}},
        '{'{KIND_QUERY, 3'd7, 4'd0, 5'd0, 0, 0, 0, Q_MAX, Q_MAX}, 1'b1, '{0, 0, ST_BAD_DOF}},
        // three-point table on axis 0: -1.0, 0.0, +1.0
        '{'{KIND_WRITE, 3'd0, 4'd0, 5'd0, -Q_UNIT, Q_UNIT, 0, 0, 0},
          1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_WRITE, 3'd0, 4'd1, 5'd0, 0, 2 * Q_UNIT, Q_UNIT, 0, 0},
          1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_WRITE, 3'd0, 4'd2, 5'd0, Q_UNIT, Q_MAX, Q_MIN, 0, 0},
          1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_SET, 3'd0, 4'd0, 5'd3, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, ST_INTERP}},
        // clamp low, including a query exactly on the first point
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_MIN, Q_UNIT},
          1'b1, '{Q_UNIT, 0, ST_CLAMP_LO}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, -Q_UNIT, 2 * Q_UNIT},
          1'b1, '{2 * Q_UNIT, 0, ST_CLAMP_LO}},
        // clamp high, with the product saturating both ways
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_MAX, Q_UNIT},
          1'b1, '{Q_MAX, Q_MIN, ST_CLAMP_HI}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_UNIT, Q_MAX},
          1'b1, '{Q_MAX, Q_MIN, ST_CLAMP_HI}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_UNIT, Q_MIN},
          1'b1, '{Q_MIN, Q_MIN, ST_CLAMP_HI}},
        // interior: mid-interval, on an inner point, negative wave
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, -Q_HALF, Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, 0, Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_HALF, -Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        // oversized count saturates to a full table
        '{'{KIND_SET, 3'd1, 4'd0, 5'd31, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd1, 4'd0, 5'd0, 0, 0, 0, Q_MAX, Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        // transactions the block must drop: bad axis write and set, spare kind
        '{'{KIND_WRITE, 3'd6, 4'd3, 5'd0, Q_MAX, Q_MAX, Q_MAX, 0, 0},
          1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_SET, 3'd7, 4'd0, 5'd5, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_SPARE, 3'd0, 4'd0, 5'd1, 0, 0, 0, 0, Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_HALF, -Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        // single point: only clamping is possible
        '{'{KIND_SET, 3'd1, 4'd0, 5'd1, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd1, 4'd0, 5'd0, 0, 0, 0, 0, Q_UNIT}, 1'b0, '{0, 0, ST_INTERP}},
        // emptied table again
        '{'{KIND_SET, 3'd0, 4'd0, 5'd0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, ST_INTERP}},
        '{'{KIND_QUERY, 3'd0, 4'd0, 5'd0, 0, 0, 0, Q_MAX, 32'sh1234_5678},
          1'b1, '{32'sh1234_5678, 0, ST_EMPTY}}
    };

    // floor(wave * gain / 2^16), saturated to 32 bits
    function automatic logic signed [31:0] scale_by_wave(logic signed [31:0] wave,
                                                         logic signed [31:0] gain);
        longint product;
        product = (longint'(wave) * longint'(gain)) >>> 16;
        if (product > longint'(Q_MAX))
            return Q_MAX;
        if (product < longint'(Q_MIN))
            return Q_MIN;
        return product[31:0];
    endfunction

    // lo + floor((hi - lo) * frac / 2^16); always lands between lo and hi
    function automatic logic signed [31:0] blend(logic signed [31:0] lo,
                                                 logic signed [31:0] hi, longint frac);
        longint step;
        step = ((longint'(hi) - longint'(lo)) * frac) >>> 16;
        return 32'(longint'(lo) + step);
    endfunction

    // Apply one accepted transaction to the mirrored state; return 1 with the
    // response when it is a query.
    function automatic bit apply_transaction(input transaction_t t, output response_t r);
        int unsigned base;
        int unsigned last;
        int unsigned seg;
        int unsigned n;
        longint      delta;
        longint      span;
        longint      frac;
        r = '{amplitude: '0, phase: '0, status: ST_BAD_DOF};
        case (t.kind)
            KIND_WRITE:
            begin
                if (t.dof < AXIS_COUNT && t.point_index < TABLE_POINTS)
                begin
                    base = t.dof * TABLE_POINTS + t.point_index;
                    pt_freq[base]  = t.point_frequency;
                    pt_gain[base]  = t.point_gain;
                    pt_phase[base] = t.point_phase;
                end
                return 1'b0;
            end
            KIND_SET:
            begin
                if (t.dof < AXIS_COUNT)
                    axis_points[t.dof] = (t.point_count > TABLE_POINTS) ?
                                         TABLE_POINTS : t.point_count;
                return 1'b0;
            end
            KIND_QUERY:
                ;
            default:
                return 1'b0;
        endcase

        if (t.dof >= AXIS_COUNT)
            return 1'b1;
        base = t.dof * TABLE_POINTS;
        n    = axis_points[t.dof];
        if (n == 0)
        begin
            r.amplitude = t.wave_amplitude;
            r.status    = ST_EMPTY;
            return 1'b1;
        end
        last = base + n - 1;
        if (t.query_frequency <= pt_freq[base])
        begin
            r.amplitude = scale_by_wave(t.wave_amplitude, pt_gain[base]);
            r.phase     = pt_phase[base];
            r.status    = ST_CLAMP_LO;
            return 1'b1;
        end
        if (t.query_frequency >= pt_freq[last])
        begin
            r.amplitude = scale_by_wave(t.wave_amplitude, pt_gain[last]);
            r.phase     = pt_phase[last];
            r.status    = ST_CLAMP_HI;
            return 1'b1;
        end
        // first interval whose upper point lies above the query, or else the last interval
        seg = base;
        while (seg + 2 < base + n && t.query_frequency >= pt_freq[seg + 1])
            seg++;
        delta = longint'(t.query_frequency) - longint'(pt_freq[seg]);
        span  = longint'(pt_freq[seg + 1]) - longint'(pt_freq[seg]);
        // out-of-order points pin the fraction to zero or one
        if (delta <= 0)
            frac = 0;
        else if (delta >= span)
            frac = FRAC_UNIT;
        else
            frac = (delta * FRAC_UNIT) / span;
        r.amplitude = scale_by_wave(t.wave_amplitude,
                                    blend(pt_gain[seg], pt_gain[seg + 1], frac));
        r.phase     = blend(pt_phase[seg], pt_phase[seg + 1], frac);
        r.status    = ST_INTERP;
        return 1'b1;
    endfunction

    // Extremes and small values show up far more often than plain chance gives.
    function automatic logic signed [31:0] any_word();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return int'($urandom_range(0, 262144)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pause_length();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Fields a transaction does not use carry junk, so the block must ignore them.
    function automatic transaction_t scrambled(logic [1:0] kind, logic [2:0] dof);
        transaction_t t;
        t.kind            = kind;
        t.dof             = dof;
        t.point_index     = $urandom;
        t.point_count     = $urandom;
        t.point_frequency = $urandom;
        t.point_gain      = $urandom;
        t.point_phase     = $urandom;
        t.query_frequency = $urandom;
        t.wave_amplitude  = $urandom;
        return t;
    endfunction

    function automatic transaction_t write_txn(logic [2:0] dof, logic [3:0] idx,
                                               logic signed [31:0] f, logic signed [31:0] g,
                                               logic signed [31:0] p);
        transaction_t t;
        t                 = scrambled(KIND_WRITE, dof);
        t.point_index     = idx;
        t.point_frequency = f;
        t.point_gain      = g;
        t.point_phase     = p;
        return t;
    endfunction

    function automatic transaction_t set_txn(logic [2:0] dof, logic [4:0] count);
        transaction_t t;
        t             = scrambled(KIND_SET, dof);
        t.point_count = count;
        return t;
    endfunction

    function automatic transaction_t query_txn(logic [2:0] dof, logic signed [31:0] q,
                                               logic signed [31:0] wave);
        transaction_t t;
        t                 = scrambled(KIND_QUERY, dof);
        t.query_frequency = q;
        t.wave_amplitude  = wave;
        return t;
    endfunction

    function automatic void note_mismatch(string what);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch: %s", what);
        mismatches++;
    endfunction

    // Offer one transaction, hold it until accepted, then log what it should
    // produce. Called at a rising edge, returns at the accepting edge.
    task automatic issue(input transaction_t t, input bit fixed, input response_t answer);
        int        gap;
        bit        yields;
        response_t predicted;
        gap = pause_length();
        if (gap > 0)
        begin
            req_ch.valid           <= 1'b0;
            req_ch.kind            <= $urandom;
            req_ch.point_frequency <= $urandom;
            req_ch.query_frequency <= $urandom;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.kind            <= t.kind;
        req_ch.dof             <= t.dof;
        req_ch.point_index     <= t.point_index;
        req_ch.point_count     <= t.point_count;
        req_ch.point_frequency <= t.point_frequency;
        req_ch.point_gain      <= t.point_gain;
        req_ch.point_phase     <= t.point_phase;
        req_ch.query_frequency <= t.query_frequency;
        req_ch.wave_amplitude  <= t.wave_amplitude;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);

        accepted_items++;
        if (t.kind != KIND_SPARE && (t.kind == KIND_QUERY || t.dof < AXIS_COUNT))
            counted_items++;
        yields = apply_transaction(t, predicted);
        if (yields)
        begin
            if (fixed)
                predicted = answer;
            awaited.push_back(predicted);
            status_seen[int'(predicted.status)]++;
        end
    endtask

    // Load a fresh table on one axis, publish its count, then probe it: on
    // points, next to points, inside intervals and at the range limits.
    task automatic load_and_probe();
        int                 freq [$];
        int                 axis;
        int                 n;
        int                 roll;
        int                 j;
        int                 k;
        int                 tmp;
        longint             room;
        logic signed [31:0] q;
        axis = $urandom_range(0, AXIS_COUNT - 1);
        roll = $urandom_range(0, 99);
        if (roll < 70)
            n = $urandom_range(1, 4);
        else if (roll < 95)
            n = $urandom_range(5, 10);
        else
            n = $urandom_range(11, TABLE_POINTS);

        if ($urandom_range(0, 1))
        begin
            // spread over the whole signed range
            repeat (n) freq.push_back($urandom);
            freq.sort();
        end
        else
        begin
            // crowd the points together, with equal neighbours now and then
            tmp = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
            repeat (n)
            begin
                freq.push_back(tmp);
                tmp += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h3_0000);
            end
        end
        if (n > 2 && $urandom_range(0, 6) == 0)
        begin
            // swap two points to leave the table out of order
            j       = $urandom_range(0, n - 1);
            k       = $urandom_range(0, n - 1);
            tmp     = freq[j];
            freq[j] = freq[k];
            freq[k] = tmp;
        end

        for (int p = 0; p < n; p++)
            issue(write_txn(axis, p, freq[p], any_word(), any_word()), 1'b0, no_answer);
        issue(set_txn(axis, (n == TABLE_POINTS) ? $urandom_range(TABLE_POINTS, 31) : n),
              1'b0, no_answer);

        repeat ($urandom_range(2, 8))
        begin
            j = $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
                0: q = freq[j];
                1: q = freq[j] + (($urandom_range(0, 1) != 0) ? 1 : -1);
                2, 3:
                begin
                    room = (j + 1 < n) ? longint'(freq[j + 1]) - longint'(freq[j]) : 0;
                    if (room > 1)
                        q = 32'(longint'(freq[j]) +
                                longint'({$urandom, $urandom} >> 1) % room);
                    else
                        q = freq[j];
                end
                4: q = ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
                default: q = $urandom;
            endcase
            issue(query_txn(axis, q, any_word()), 1'b0, no_answer);
        end
    endtask

    // Stimulus: reset, fill every point so no query can touch an unwritten
    // entry, walk the directed plan, then a random mix until the goal is met.
    initial
    begin : stimulus
        int roll;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.kind            = '0;
        req_ch.dof             = '0;
        req_ch.point_index     = '0;
        req_ch.point_count     = '0;
        req_ch.point_frequency = '0;
        req_ch.point_gain      = '0;
        req_ch.point_phase     = '0;
        req_ch.query_frequency = '0;
        req_ch.wave_amplitude  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // counts are still zero here, so these writes stay invisible to queries
        for (int a = 0; a < AXIS_COUNT; a++)
            for (int p = 0; p < TABLE_POINTS; p++)
                issue(write_txn(a, p, any_word(), any_word(), any_word()), 1'b0, no_answer);

        foreach (plan[r])
            issue(plan[r].txn, plan[r].fixed, plan[r].answer);

        while (counted_items < ITEM_GOAL)
        begin
            // roughly one sequence in five runs with no idling on either side
            no_idle = ($urandom_range(0, 4) == 0);
            roll    = $urandom_range(0, 99);
            if (roll < 55)
                load_and_probe();
            else if (roll < 75)
                repeat ($urandom_range(1, 4))
                    issue(query_txn($urandom_range(0, 7), any_word(), any_word()),
                          1'b0, no_answer);
            else if (roll < 85)
                issue(write_txn($urandom_range(0, 7), $urandom_range(0, 15), any_word(),
                                any_word(), any_word()), 1'b0, no_answer);
            else if (roll < 95)
                issue(set_txn($urandom_range(0, 7), $urandom_range(0, 31)), 1'b0, no_answer);
            else
                issue(scrambled(KIND_SPARE, $urandom), 1'b0, no_answer);
        end
        req_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // drain, then linger in case the block emits anything extra
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions in, %0d responses checked: %0d interpolated,",
                 accepted_items, results_checked, status_seen[int'(ST_INTERP)]);
        $display("  %0d clamped low, %0d clamped high, %0d empty, %0d bad axis; %0d mismatches",
                 status_seen[int'(ST_CLAMP_LO)], status_seen[int'(ST_CLAMP_HI)],
                 status_seen[int'(ST_EMPTY)], status_seen[int'(ST_BAD_DOF)], mismatches);
        if (mismatches == 0 && awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Response side: random stalls, plus two long hold-offs that let the
    // block back up and stall its input while the stimulus keeps offering.
    initial
    begin : response_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((holdoffs_done == 0 && results_checked >= 200) ||
                (holdoffs_done == 1 && results_checked >= 600))
            begin
                holdoffs_done++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            stall = pause_length();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare every accepted response with the oldest one owed.
    always @(posedge clk)
    begin : response_check
        response_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (awaited.size() == 0)
                note_mismatch($sformatf("response with none owed: amp %h phase %h status %0d",
                                        rsp_ch.response_amplitude, rsp_ch.response_phase,
                                        rsp_ch.status));
            else
            begin
                want = awaited.pop_front();
                if (rsp_ch.response_amplitude !== want.amplitude)
                    note_mismatch($sformatf("response %0d amplitude: expected %h, got %h",
                                            results_checked, want.amplitude,
                                            rsp_ch.response_amplitude));
                if (rsp_ch.response_phase !== want.phase)
                    note_mismatch($sformatf("response %0d phase: expected %h, got %h",
                                            results_checked, want.phase,
                                            rsp_ch.response_phase));
                if (rsp_ch.status !== want.status)
                    note_mismatch($sformatf("response %0d status: expected %0d, got %0d",
                                            results_checked, want.status, rsp_ch.status));
                results_checked++;
            end
        end
    end

    // Abort if neither channel moves a transaction for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d responses owed",
                     quiet_cycles, awaited.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
